@@ rtl/core/mts_pkg.sv @@
// constants, codes and types shared by the melody tone sequencer
// no dependencies
`default_nettype none

package mts_pkg;

   localparam int MAX_NOTES  = 64;
   localparam int NOTE_IDX_W = $clog2(MAX_NOTES);
   localparam int SLOT_W     = 6;
   localparam int LEN_W      = 7;
   localparam int FREQ_W     = 16;
   localparam int DUR_W      = 16;
   localparam int PAUSE_W    = 16;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   typedef logic [1:0] op_type;

   localparam op_type OP_TICK = 2'd0;
   localparam op_type OP_LOAD = 2'd1;
   localparam op_type OP_PLAY = 2'd2;
   localparam op_type OP_STOP = 2'd3;

   // register word index on the configuration port
   localparam logic REG_PAUSE_LENGTH = 1'b0;

   localparam logic [PAUSE_W-1:0] PAUSE_RESET = PAUSE_W'(50);

   typedef struct packed {
      logic [DUR_W-1:0]  duration;
      logic [FREQ_W-1:0] freq;
   } note_entry_type;

   typedef struct packed {
      logic                  tone_on;
      logic [FREQ_W-1:0]     tone_freq;
      logic                  playing;
      logic [NOTE_IDX_W-1:0] note_index;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/melody_tone_sequencer.sv @@
// Melody tone sequencer: usage notes
//
// Requests arrive on req_* (valid/stall) and each gives exactly one response
// on rsp_*. A request is tick (one millisecond), load note, play or stop.
// Loads write the 64-entry note table and only take effect while stopped.
// The response shows tone enable, tone frequency, playing flag and note index
// as they stand after the request.
// A response enters the output buffer when its request is taken.
// Throughput: one request per cycle while req_stall is low; the note table's
// two registered read ports (current and next note) give note changes no bubble.
// A two-entry output buffer holds responses while rsp_stall is high; req_stall
// rises only when both entries are full, so a request is still taken while
// one finished response waits.
// Reset (synchronous) stops playback, sets note index to 0, empties the output
// buffer and sets the pause length to 50 ms. Note table contents are not
// cleared; slots must be loaded before they are played.
// The pause length register sits at byte address 0 of the APB port and must
// only be written while no request is in flight.
// Depends on mts_pkg.
`default_nettype none

module melody_tone_sequencer (
   input  wire                            clock,
   input  wire                            reset,
   // request channel
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire mts_pkg::op_type           req_operation,
   input  wire [mts_pkg::SLOT_W-1:0]      req_note_slot,
   input  wire [mts_pkg::FREQ_W-1:0]      req_note_freq,
   input  wire [mts_pkg::DUR_W-1:0]       req_note_duration,
   input  wire [mts_pkg::LEN_W-1:0]       req_melody_length,
   // response channel
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic                           rsp_tone_on,
   output logic [mts_pkg::FREQ_W-1:0]     rsp_tone_freq,
   output logic                           rsp_playing,
   output logic [mts_pkg::NOTE_IDX_W-1:0] rsp_note_index,
   // configuration port
   input  wire                            psel,
   input  wire                            penable,
   input  wire                            pwrite,
   input  wire [mts_pkg::APB_ADDR_W-1:0]  paddr,
   input  wire [mts_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [mts_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready
);
   import mts_pkg::*;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NOTES);

   // note table and its read ports
   note_entry_type note_mem [MAX_NOTES];
   note_entry_type rd_cur_ff;
   note_entry_type rd_next_ff;
   logic [FREQ_W-1:0] freq0_ff;

   // sequencer state
   logic                  active_ff, active_in;
   logic                  in_pause_ff, in_pause_in;
   logic [NOTE_IDX_W-1:0] cur_note_ff, cur_note_in;
   logic [DUR_W-1:0]      elapsed_ff, elapsed_in;
   logic [LEN_W-1:0]      notes_ff, notes_in;
   logic [PAUSE_W-1:0]    pause_len_ff, pause_len_in;

   // output buffer
   rsp_type   head_ff, head_in;
   rsp_type   skid_ff, skid_in;
   logic [1:0] cnt_ff, cnt_in;

   logic           req_take;
   logic           rsp_take;
   logic           wr_en;
   logic           play_start;
   logic           advance;
   logic [DUR_W-1:0] elapsed_sat;
   logic [FREQ_W-1:0] cur_freq;
   logic           sounding;
   rsp_type        new_rsp;
   logic           csr_write;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      pause_len_in = pause_len_ff;
      if (csr_write && paddr[2] == REG_PAUSE_LENGTH && paddr[1:0] == 2'b00) begin
         pause_len_in = pwdata[PAUSE_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_PAUSE_LENGTH && paddr[1:0] == 2'b00) begin
         prdata = APB_DATA_W'(pause_len_ff);
      end
   end

   // ---------------- sequencer next state ----------------
   assign elapsed_sat = (elapsed_ff == {DUR_W{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      active_in   = active_ff;
      in_pause_in = in_pause_ff;
      cur_note_in = cur_note_ff;
      elapsed_in  = elapsed_ff;
      notes_in    = notes_ff;
      wr_en       = 1'b0;
      play_start  = 1'b0;
      advance     = 1'b0;
      if (req_take) begin
         unique case (req_operation)
            OP_TICK: begin
               if (active_ff) begin
                  elapsed_in = elapsed_sat;
                  if (in_pause_ff) begin
                     if (elapsed_sat >= pause_len_ff) begin
                        in_pause_in = 1'b0;
                        if ({1'b0, cur_note_ff} + 1'b1 >= notes_ff) begin
                           active_in = 1'b0;
                        end else begin
                           advance     = 1'b1;
                           cur_note_in = cur_note_ff + 1'b1;
                           elapsed_in  = '0;
                        end
                     end
                  end else if (elapsed_sat >= rd_cur_ff.duration) begin
                     in_pause_in = 1'b1;
                     elapsed_in  = '0;
                  end
               end
            end
            OP_LOAD: begin
               wr_en = !active_ff && (LEN_W'(req_note_slot) < LEN_MAX);
            end
            OP_PLAY: begin
               if (!active_ff && req_melody_length != '0) begin
                  play_start  = 1'b1;
                  notes_in    = (req_melody_length > LEN_MAX) ? LEN_MAX : req_melody_length;
                  cur_note_in = '0;
                  active_in   = 1'b1;
                  in_pause_in = 1'b0;
                  elapsed_in  = '0;
               end
            end
            OP_STOP: begin
               active_in   = 1'b0;
               in_pause_in = 1'b0;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   // frequency of the note that is current after this request
   always_comb begin
      priority if (play_start) begin
         cur_freq = freq0_ff;
      end else if (advance) begin
         cur_freq = rd_next_ff.freq;
      end else begin
         cur_freq = rd_cur_ff.freq;
      end
   end

   assign sounding = active_in && !in_pause_in && (cur_freq != '0);

   always_comb begin
      new_rsp.tone_on    = sounding;
      new_rsp.tone_freq  = sounding ? cur_freq : '0;
      new_rsp.playing    = active_in;
      new_rsp.note_index = cur_note_in;
   end

   // ---------------- output buffer ----------------
   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      cnt_in  = cnt_ff;
      priority if (req_take && !rsp_take) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 2'd0) begin
            head_in = new_rsp;
         end else begin
            skid_in = new_rsp;
         end
      end else if (req_take && rsp_take) begin
         if (cnt_ff == 2'd1) begin
            head_in = new_rsp;
         end else begin
            head_in = skid_ff;
            skid_in = new_rsp;
         end
      end else if (rsp_take) begin
         cnt_in  = cnt_ff - 1'b1;
         head_in = skid_ff;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign rsp_tone_on    = head_ff.tone_on;
   assign rsp_tone_freq  = head_ff.tone_freq;
   assign rsp_playing    = head_ff.playing;
   assign rsp_note_index = head_ff.note_index;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         in_pause_ff  <= 1'b0;
         cur_note_ff  <= '0;
         elapsed_ff   <= '0;
         notes_ff     <= '0;
         pause_len_ff <= PAUSE_RESET;
         cnt_ff       <= 2'd0;
      end else begin
         active_ff    <= active_in;
         in_pause_ff  <= in_pause_in;
         cur_note_ff  <= cur_note_in;
         elapsed_ff   <= elapsed_in;
         notes_ff     <= notes_in;
         pause_len_ff <= pause_len_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // note table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem[req_note_slot[NOTE_IDX_W-1:0]] <= '{duration: req_note_duration,
                                                      freq: req_note_freq};
      end
   end

   always_ff @(posedge clock) begin
      rd_cur_ff  <= note_mem[cur_note_in];
      rd_next_ff <= note_mem[cur_note_in + 1'b1];
   end

   // shadow of slot 0 frequency so a play request can sound at once
   always_ff @(posedge clock) begin
      if (wr_en && req_note_slot[NOTE_IDX_W-1:0] == '0) begin
         freq0_ff <= req_note_freq;
      end
   end

   // ---------------- assertions ----------------
   a_note_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ({1'b0, cur_note_ff} < notes_ff))
      else $error("current note beyond melody length");

   a_tone_needs_play: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tone_on) |-> rsp_playing)
      else $error("tone enabled while not playing");

   a_muted_freq_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_tone_on) |-> (rsp_tone_freq == '0))
      else $error("muted response carries a frequency");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count overflow");

   a_no_load_while_playing: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !active_ff)
      else $error("note table written during playback");

endmodule

`default_nettype wire

@@ test/melody_tone_sequencer_tb.sv @@
// testbench for the melody tone sequencer: random and directed requests, pause length
// writes and response stalls, with every response checked against a playback predictor
// depends on mts_pkg and the melody_tone_sequencer rtl
`timescale 1ns / 1ps

module melody_tone_sequencer_tb;
   import mts_pkg::*;

   localparam int CLK_HALF        = 6;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int REPORT_MAX      = 10;
   localparam int NUM_PHASES      = 5;

   class tone_scoreboard;
      bit [FREQ_W-1:0]     mem_freq[MAX_NOTES];
      bit [DUR_W-1:0]      mem_dur[MAX_NOTES];
      bit                  written[MAX_NOTES];
      bit                  active;
      bit                  in_pause;
      bit [NOTE_IDX_W-1:0] cur_note;
      bit [15:0]           elapsed;
      bit [LEN_W-1:0]      n_notes;
      bit [PAUSE_W-1:0]    pause_len;
      rsp_type             expected_q[$];
      int                  failures;

      function new();
         pause_len = PAUSE_RESET;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // applies one accepted request; returns 0 when the block just ignores it
      function bit note_request(op_type op, bit [SLOT_W-1:0] slot, bit [FREQ_W-1:0] freq,
                                bit [DUR_W-1:0] dur, bit [LEN_W-1:0] len);
         rsp_type r;
         bit      effective;
         effective = 1'b0;
         case (op)
            OP_TICK: begin
               if (active) begin
                  effective = 1'b1;
                  if (elapsed != 16'hffff) elapsed++;
                  if (in_pause) begin
                     if (elapsed >= pause_len) begin
                        in_pause = 1'b0;
                        if (int'(cur_note) + 1 >= int'(n_notes)) begin
                           active = 1'b0;
                        end else begin
                           cur_note++;
                           elapsed = '0;
                        end
                     end
                  end else if (elapsed >= mem_dur[cur_note]) begin
                     in_pause = 1'b1;
                     elapsed  = '0;
                  end
               end
            end
            OP_LOAD: begin
               if (!active) begin
                  effective      = 1'b1;
                  mem_freq[slot] = freq;
                  mem_dur[slot]  = dur;
                  written[slot]  = 1'b1;
               end
            end
            OP_PLAY: begin
               if (!active && len != 0) begin
                  effective = 1'b1;
                  n_notes   = (len > MAX_NOTES) ? LEN_W'(MAX_NOTES) : len;
                  cur_note  = '0;
                  active    = 1'b1;
                  in_pause  = 1'b0;
                  elapsed   = '0;
               end
            end
            OP_STOP: begin
               effective = active;
               active    = 1'b0;
               in_pause  = 1'b0;
            end
         endcase
         r.playing    = active;
         r.note_index = cur_note;
         r.tone_on    = active && !in_pause && mem_freq[cur_note] != 0;
         r.tone_freq  = r.tone_on ? mem_freq[cur_note] : '0;
         expected_q.push_back(r);
         return effective;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("response with nothing expected: tone_on %0b freq %0d playing %0b note %0d",
                        got.tone_on, got.tone_freq, got.playing, got.note_index);
            return;
         end
         want = expected_q.pop_front();
         if (got.tone_on !== want.tone_on || got.tone_freq !== want.tone_freq ||
             got.playing !== want.playing || got.note_index !== want.note_index) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display({"response mismatch (expected/actual): tone_on %0b/%0b freq %0d/%0d",
                         " playing %0b/%0b note %0d/%0d"},
                        want.tone_on, got.tone_on, want.tone_freq, got.tone_freq,
                        want.playing, got.playing, want.note_index, got.note_index);
         end
      endfunction
   endclass

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   op_type                req_operation     = OP_TICK;
   logic [SLOT_W-1:0]     req_note_slot     = '0;
   logic [FREQ_W-1:0]     req_note_freq     = '0;
   logic [DUR_W-1:0]      req_note_duration = '0;
   logic [LEN_W-1:0]      req_melody_length = '0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic                  rsp_tone_on;
   logic [FREQ_W-1:0]     rsp_tone_freq;
   logic                  rsp_playing;
   logic [NOTE_IDX_W-1:0] rsp_note_index;
   logic                  psel              = 1'b0;
   logic                  penable           = 1'b0;
   logic                  pwrite            = 1'b0;
   logic [APB_ADDR_W-1:0] paddr             = '0;
   logic [APB_DATA_W-1:0] pwdata            = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   tone_scoreboard sb;
   bit             idle_on         = 1'b0;
   int             rsp_hold_cycles = 0;
   int             cycles          = 0;

   melody_tone_sequencer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_note_slot     (req_note_slot),
      .req_note_freq     (req_note_freq),
      .req_note_duration (req_note_duration),
      .req_melody_length (req_melody_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tone_on       (rsp_tone_on),
      .rsp_tone_freq     (rsp_tone_freq),
      .rsp_playing       (rsp_playing),
      .rsp_note_index    (rsp_note_index),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_tone_on, rsp_tone_freq, rsp_playing, rsp_note_index});
   end

   // response side: random stall before each response, or one long hold when asked
   initial begin : rsp_side
      int hold;
      forever begin
         hold = idle_on ? $urandom_range(0, 15) : 0;
         if (rsp_hold_cycles != 0) begin
            hold            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [FREQ_W-1:0] pick_freq();
      return ($urandom_range(0, 3) == 0) ? FREQ_W'(0) : FREQ_W'($urandom);
   endfunction

   // mostly short notes so that melodies run to their end
   function automatic logic [DUR_W-1:0] pick_dur();
      return ($urandom_range(0, 15) == 0) ? DUR_W'($urandom) : DUR_W'($urandom_range(0, 6));
   endfunction

   // called on a rising edge; returns on the edge at which the request is taken
   task automatic send_request(input op_type op, input logic [SLOT_W-1:0] slot,
                               input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur,
                               input logic [LEN_W-1:0] len, output bit effective);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_note_slot     <= slot;
      req_note_freq     <= freq;
      req_note_duration <= dur;
      req_melody_length <= len;
      do @(posedge clock); while (req_stall);
      effective = sb.note_request(op, slot, freq, dur, len);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the pause length, then read it back in a second transfer
   task automatic write_pause_length(input logic [PAUSE_W-1:0] value);
      logic [APB_DATA_W-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_ADDR_W'(4 * REG_PAUSE_LENGTH);
      pwdata  <= APB_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.pause_len = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[PAUSE_W-1:0] !== value) begin
         sb.failures++;
         if (sb.failures <= REPORT_MAX)
            $display("pause length read back (expected/actual): %0d/%0d", value,
                     readback[PAUSE_W-1:0]);
      end
   endtask

   initial begin : stimulus
      bit                 ok;
      int                 counted;
      int                 pick;
      op_type             op;
      logic [SLOT_W-1:0]  slot;
      logic [FREQ_W-1:0]  freq;
      logic [DUR_W-1:0]   dur;
      logic [LEN_W-1:0]   len;
      logic [PAUSE_W-1:0] pause_plan [NUM_PHASES];

      sb = new();
      pause_plan = '{16'd3, 16'd0, 16'hffff, 16'd1, 16'd0};
      pause_plan[4] = PAUSE_W'($urandom_range(0, 7));
      repeat (8) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // directed, reset pause length: idle requests, extremes, ignored requests
      send_request(OP_TICK, '0, '0, '0, '0, ok);
      send_request(OP_STOP, '0, '0, '0, '0, ok);
      send_request(OP_LOAD, 6'd0, 16'hffff, 16'd0, '0, ok);
      send_request(OP_LOAD, 6'd1, 16'd0, 16'd2, '0, ok);
      send_request(OP_LOAD, 6'd2, 16'd1, 16'd1, '0, ok);
      send_request(OP_LOAD, 6'd63, 16'hffff, 16'hffff, '0, ok);
      send_request(OP_PLAY, '0, '0, '0, 7'd0, ok);
      send_request(OP_PLAY, '0, '0, '0, 7'd3, ok);
      send_request(OP_LOAD, 6'd5, 16'h1234, 16'd3, '0, ok);
      send_request(OP_PLAY, '0, '0, '0, 7'd2, ok);
      send_request(OP_TICK, '0, '0, '0, '0, ok);
      send_request(OP_TICK, '0, '0, '0, '0, ok);
      send_request(OP_STOP, '0, '0, '0, '0, ok);
      send_request(OP_TICK, '0, '0, '0, '0, ok);
      wait_for_responses();

      // zero pause: walk the three notes, the rest among them, to the end of the melody
      write_pause_length(16'd0);
      send_request(OP_PLAY, '0, '0, '0, 7'd3, ok);
      repeat (8) send_request(OP_TICK, '0, '0, '0, '0, ok);
      wait_for_responses();

      // fill the rest of the table so that any length can be played
      for (int s = 0; s < MAX_NOTES; s++) begin
         if (!sb.written[s])
            send_request(OP_LOAD, SLOT_W'(s), pick_freq(), pick_dur(), LEN_W'($urandom), ok);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_for_responses();
         write_pause_length(pause_plan[ph]);
         idle_on = (ph % 2 == 0);
         // long hold on the response side while requests keep coming
         if (ph == 1) rsp_hold_cycles = 150;
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (sb.active)
               op = (pick < 80) ? OP_TICK : (pick < 88) ? OP_STOP : (pick < 94) ? OP_LOAD : OP_PLAY;
            else
               op = (pick < 10) ? OP_TICK : (pick < 15) ? OP_STOP : (pick < 55) ? OP_LOAD : OP_PLAY;
            slot = SLOT_W'($urandom);
            freq = pick_freq();
            dur  = pick_dur();
            len  = LEN_W'($urandom);
            if (op == OP_PLAY) begin
               pick = $urandom_range(0, 19);
               if (pick == 0)
                  len = '0;
               else if (pick < 4)
                  len = LEN_W'($urandom_range(64, 127));
               else if (pick < 14)
                  len = LEN_W'($urandom_range(1, 6));
               else
                  len = LEN_W'($urandom_range(1, 64));
            end
            send_request(op, slot, freq, dur, len, ok);
            counted++;
         end
      end

      wait_for_responses();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
